/* sv/msd_pkg.sv */
// Package for the magnitude stability detector.
// Holds shared widths, register indexes, transition codes and the state struct.
// No dependencies.
package msd_pkg;

    localparam int MAG_W   = 20;
    localparam int GAIN_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int AVG_W   = MAG_W + FRAC_W;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [IDX_W-1:0] REG_MIN_LEVEL = 1'd0;
    localparam logic [IDX_W-1:0] REG_GAIN      = 1'd1;

    localparam logic [MAG_W-1:0]  MIN_LEVEL_RST = 20'd160;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd6554;

    typedef enum logic [1:0] {
        TR_NONE = 2'd0,
        TR_UP   = 2'd1,
        TR_DOWN = 2'd2
    } t_transition;

    typedef struct packed {
        logic [AVG_W-1:0] avg;
        logic             primed;
        logic             was_stable;
    } t_state;

endpackage

/* sv/msd_core.sv */
// Per-beat datapath of the magnitude stability detector.
// Moves the running average, tests stability and forms the transition code.
// Depends on msd_pkg.
module msd_core (
    input  logic [msd_pkg::MAG_W-1:0]  i_mag,
    input  logic [msd_pkg::MAG_W-1:0]  i_min_level,
    input  logic [msd_pkg::GAIN_W-1:0] i_gain,
    input  msd_pkg::t_state            i_state,
    output msd_pkg::t_state            o_state,
    output logic                       o_is_stable,
    output msd_pkg::t_transition       o_transition
);

    localparam int PROD_W = msd_pkg::AVG_W + msd_pkg::GAIN_W;

    logic [msd_pkg::AVG_W-1:0] s;
    logic                      s_ge;
    logic [msd_pkg::AVG_W-1:0] diff;
    logic [PROD_W-1:0]         prod;
    logic [msd_pkg::AVG_W-1:0] step;
    logic [msd_pkg::AVG_W-1:0] avg_moved;
    logic [msd_pkg::AVG_W-1:0] avg_new;
    logic                      fail;
    logic                      stable;

    assign s     = {i_mag, {msd_pkg::FRAC_W{1'b0}}};
    assign s_ge  = s >= i_state.avg;
    assign diff  = s_ge ? (s - i_state.avg) : (i_state.avg - s);
    assign prod  = diff * i_gain;
    assign step  = prod[PROD_W-1:msd_pkg::FRAC_W];
    assign avg_moved = s_ge ? (i_state.avg + step) : (i_state.avg - step);
    assign avg_new   = i_state.primed ? avg_moved : s;
    assign fail      = i_mag < i_min_level;
    assign stable    = {s, 1'b0} > {1'b0, avg_new};

    always_comb begin
        o_state = i_state;
        if (fail) begin
            o_is_stable = 1'b0;
            o_state.was_stable = 1'b0;
        end else begin
            o_is_stable = stable;
            o_state.avg = avg_new;
            o_state.primed = 1'b1;
            o_state.was_stable = stable;
        end
        if (o_is_stable && !i_state.was_stable) begin
            o_transition = msd_pkg::TR_UP;
        end else if (!o_is_stable && i_state.was_stable) begin
            o_transition = msd_pkg::TR_DOWN;
        end else begin
            o_transition = msd_pkg::TR_NONE;
        end
    end

endmodule

/* sv/magnitude_stability_detector_unit.sv */
// Top level of the magnitude stability detector.
// Input register, configuration registers, state and result register around msd_core.
// Depends on msd_pkg and msd_core.
//
//  channel   dir  tdata bits (low first)                     beats
//  s_axis    in   magnitude[19:0], zero pad to 24            one sample
//  m_axis    out  is_stable[0], transition[2:1], pad to 8    one result per sample
//  cfg       in   i_cfg_idx 0 min_level, 1 smoothing_gain    one write per cycle
//
// One beat per cycle unless m_axis stalls; samples pass input, then result register.
// The loop through subtract, 36x16 multiply, add and compare on the average sets the clock.
// Reset clears the average, flags and valids and restores default register values.
// A stall on m_axis holds the result; s_axis keeps taking a beat while the
// input register is empty or moves on.
module magnitude_stability_detector_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [msd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // magnitude[19:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [msd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // is_stable, transition[1:0]
    input  logic                             i_cfg_we,
    input  logic [msd_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [msd_pkg::CFG_W-1:0]        i_cfg_data
);

    logic                        r_in_valid;
    logic [msd_pkg::MAG_W-1:0]   r_mag;
    logic [msd_pkg::MAG_W-1:0]   r_min_level;
    logic [msd_pkg::GAIN_W-1:0]  r_gain;
    msd_pkg::t_state             r_state;
    msd_pkg::t_state             n_state;
    logic                        r_out_valid;
    logic                        r_out_stable;
    msd_pkg::t_transition        r_out_code;
    logic                        n_stable;
    msd_pkg::t_transition        n_code;
    logic                        advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(msd_pkg::OUT_TDATA_W-3){1'b0}}, r_out_code, r_out_stable};

    msd_core u_core (
        .i_mag        (r_mag),
        .i_min_level  (r_min_level),
        .i_gain       (r_gain),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_is_stable  (n_stable),
        .o_transition (n_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= msd_pkg::MIN_LEVEL_RST;
            r_gain      <= msd_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msd_pkg::REG_MIN_LEVEL: r_min_level <= i_cfg_data[msd_pkg::MAG_W-1:0];
                msd_pkg::REG_GAIN:      r_gain <= i_cfg_data[msd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_mag <= s_axis_tdata[msd_pkg::MAG_W-1:0];
        end
        if (advance && r_in_valid) begin
            r_out_stable <= n_stable;
            r_out_code   <= n_code;
        end
    end

endmodule

/* sv/msd_checker.sv */
// Port-level checks for the magnitude stability detector.
// Watches the top level's stream ports; bound to magnitude_stability_detector_unit.
// Depends on msd_pkg.
module msd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [msd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_code_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:1] == msd_pkg::TR_NONE
            || m_axis_tdata[2:1] == msd_pkg::TR_UP
            || m_axis_tdata[2:1] == msd_pkg::TR_DOWN)
        else $error("undefined transition code");

    a_code_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] != msd_pkg::TR_NONE
            |-> m_axis_tdata[0] == (m_axis_tdata[2:1] == msd_pkg::TR_UP))
        else $error("transition code disagrees with stable flag");

    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind magnitude_stability_detector_unit msd_checker u_msd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/magnitude_stability_detector_unit_tb.sv */
// Testbench for magnitude_stability_detector_unit: directed and random sample streams with
// random gaps and stalls, each result checked against an in-bench moving-average predictor.
// Depends on msd_pkg and the magnitude_stability_detector_unit RTL.
`timescale 1ns / 1ps

module magnitude_stability_detector_unit_tb;

    typedef struct {
        logic                 is_stable;
        msd_pkg::t_transition transition;
    } t_verdict;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [msd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // magnitude[19:0], pad
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [msd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // is_stable, transition[1:0], pad
    logic                            i_cfg_we;
    logic [msd_pkg::IDX_W-1:0]       i_cfg_idx;
    logic [msd_pkg::CFG_W-1:0]       i_cfg_data;

    logic [msd_pkg::MAG_W-1:0]  min_level_q;
    logic [msd_pkg::GAIN_W-1:0] gain_q;
    logic [msd_pkg::AVG_W-1:0]  avg_q;
    logic                       primed_q;
    logic                       was_stable_q;

    t_verdict expected_verdicts[$];
    int       mismatch_count;
    bit       idle_on;

    magnitude_stability_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_verdict predict_verdict(input logic [msd_pkg::MAG_W-1:0] mag);
        logic [msd_pkg::AVG_W-1:0]                  s;
        logic [msd_pkg::AVG_W+msd_pkg::GAIN_W-1:0]  step;
        logic                                       stable;
        t_verdict                                   v;
        if (mag < min_level_q) begin
            v.is_stable  = 1'b0;
            v.transition = was_stable_q ? msd_pkg::TR_DOWN : msd_pkg::TR_NONE;
            was_stable_q = 1'b0;
            return v;
        end
        s = {mag, {msd_pkg::FRAC_W{1'b0}}};
        if (!primed_q) begin
            avg_q    = s;
            primed_q = 1'b1;
        end else if (s >= avg_q) begin
            step  = ((s - avg_q) * gain_q) >> msd_pkg::FRAC_W;
            avg_q = avg_q + step[msd_pkg::AVG_W-1:0];
        end else begin
            step  = ((avg_q - s) * gain_q) >> msd_pkg::FRAC_W;
            avg_q = avg_q - step[msd_pkg::AVG_W-1:0];
        end
        stable = {s, 1'b0} > {1'b0, avg_q};
        v.is_stable = stable;
        if (stable && !was_stable_q) begin
            v.transition = msd_pkg::TR_UP;
        end else if (!stable && was_stable_q) begin
            v.transition = msd_pkg::TR_DOWN;
        end else begin
            v.transition = msd_pkg::TR_NONE;
        end
        was_stable_q = stable;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, tdata %h",
                                          m_axis_tdata));
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== exp_v.is_stable)
                    report_mismatch($sformatf("is_stable %b, expected %b",
                                              m_axis_tdata[0], exp_v.is_stable));
                if (m_axis_tdata[2:1] !== exp_v.transition)
                    report_mismatch($sformatf("transition %0d, expected %0d",
                                              m_axis_tdata[2:1], exp_v.transition));
            end
        end
    end

    // result side: while idle_on is set, stall a random number of cycles before each beat
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = idle_on ? $urandom_range(0, 19) : 0;
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_sample(input logic [msd_pkg::MAG_W-1:0] mag);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(msd_pkg::IN_TDATA_W-msd_pkg::MAG_W){1'b0}}, mag};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_verdicts.push_back(predict_verdict(mag));
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [msd_pkg::IDX_W-1:0] idx,
                             input logic [msd_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == msd_pkg::REG_MIN_LEVEL)
            min_level_q = value[msd_pkg::MAG_W-1:0];
        else
            gain_q = value[msd_pkg::GAIN_W-1:0];
    endtask

    function automatic logic [msd_pkg::MAG_W-1:0] clamp_mag(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'({msd_pkg::MAG_W{1'b1}}))
            return '1;
        return v[msd_pkg::MAG_W-1:0];
    endfunction

    function automatic logic [msd_pkg::MAG_W-1:0] pick_magnitude();
        case ($urandom_range(0, 9))
            0, 1, 2: return msd_pkg::MAG_W'($urandom);
            3:       return clamp_mag(longint'(min_level_q) + $urandom_range(0, 4) - 2);
            4:       return clamp_mag(longint'(avg_q >> (msd_pkg::FRAC_W + 1))
                                      + $urandom_range(0, 4) - 2);
            5:       return msd_pkg::MAG_W'($urandom_range(0, 255));
            6:       return $urandom_range(0, 1) ? '1 : '0;
            default: return clamp_mag(longint'(avg_q >> msd_pkg::FRAC_W)
                                      + $urandom_range(0, 128) - 64);
        endcase
    endfunction

    // zero sample qualifies as the first one only with a zero cutoff
    task automatic test_zero_first_sample();
        idle_on = 1'b1;
        write_reg(msd_pkg::REG_MIN_LEVEL, '0);
        send_sample('0);
        send_sample('0);
        send_sample(20'd1);
        send_sample('1);
        send_sample('0);
        settle_block();
    endtask

    task automatic test_hard_failure();
        idle_on = 1'b0;
        write_reg(msd_pkg::REG_MIN_LEVEL, msd_pkg::CFG_W'(msd_pkg::MIN_LEVEL_RST));
        send_sample(20'd159);
        send_sample(20'd160);
        send_sample('1);
        send_sample(20'd160);
        send_sample('0);
        send_sample('1);
        send_sample('0);
        settle_block();
    endtask

    task automatic test_gain_extremes();
        idle_on = 1'b1;
        write_reg(msd_pkg::REG_GAIN, '0);
        send_sample('1);
        send_sample(20'd200);
        send_sample(20'h55555);
        settle_block();
        write_reg(msd_pkg::REG_GAIN, msd_pkg::CFG_W'({msd_pkg::GAIN_W{1'b1}}));
        send_sample(20'd160);
        send_sample('1);
        send_sample(20'h7FFFF);
        send_sample(20'd300);
        settle_block();
    endtask

    task automatic test_min_level_max();
        idle_on = 1'b0;
        write_reg(msd_pkg::REG_MIN_LEVEL, msd_pkg::CFG_W'({msd_pkg::MAG_W{1'b1}}));
        send_sample(20'hFFFFE);
        send_sample('1);
        send_sample(20'hAAAAA);
        settle_block();
    endtask

    task automatic test_random_stream();
        logic [msd_pkg::MAG_W-1:0]  lvl;
        logic [msd_pkg::GAIN_W-1:0] g;
        logic [msd_pkg::CFG_W-1:0]  word;
        for (int phase = 0; phase < 13; phase++) begin
            case ($urandom_range(0, 9))
                0:       lvl = '0;
                1:       lvl = '1;
                2:       lvl = msd_pkg::MIN_LEVEL_RST;
                3:       lvl = msd_pkg::MAG_W'($urandom);
                4, 5:    lvl = msd_pkg::MAG_W'($urandom_range(0, 4095));
                default: lvl = msd_pkg::MAG_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       g = '0;
                1:       g = '1;
                2:       g = 16'd1;
                default: g = msd_pkg::GAIN_W'($urandom);
            endcase
            write_reg(msd_pkg::REG_MIN_LEVEL, msd_pkg::CFG_W'(lvl));
            word = msd_pkg::CFG_W'($urandom);
            word[msd_pkg::GAIN_W-1:0] = g;
            write_reg(msd_pkg::REG_GAIN, word);
            for (int k = 0; k < 100; k++) begin
                if (k % 25 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                send_sample(pick_magnitude());
            end
            settle_block();
        end
    endtask

    initial begin
        mismatch_count = 0;
        idle_on        = 1'b0;
        min_level_q    = msd_pkg::MIN_LEVEL_RST;
        gain_q         = msd_pkg::GAIN_RST;
        avg_q          = '0;
        primed_q       = 1'b0;
        was_stable_q   = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= msd_pkg::REG_MIN_LEVEL;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_first_sample();
        test_hard_failure();
        test_gain_extremes();
        test_min_level_max();
        test_random_stream();

        settle_block();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout, %0d results outstanding", expected_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
